/* rtl/core/fan_speed_controller_top_macros.svh */
// Assertion macros shared by the fan speed controller RTL.
`ifndef FAN_SPEED_CONTROLLER_TOP_MACROS_SVH
`define FAN_SPEED_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Implication in the same cycle, disabled while reset is asserted.
`define FSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fan speed controller assertion failed");

// Implication in the next cycle, disabled while reset is asserted.
`define FSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fan speed controller assertion failed");

`else

`define FSC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/fsc_pkg.sv */
// Package with the microcode types, step addresses and control store of the fan controller.
package fsc_pkg;

    // Fan mode codes.
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_SPINUP = 2'd1;
    localparam logic [1:0] MODE_ON     = 2'd2;

    // Configuration register indexes.
    localparam logic [7:0] REG_TEMP_ON     = 8'd0;
    localparam logic [7:0] REG_TEMP_FULL   = 8'd1;
    localparam logic [7:0] REG_TEMP_HYST   = 8'd2;
    localparam logic [7:0] REG_SPINUP_TIME = 8'd3;
    localparam logic [7:0] REG_SPINUP_DUTY = 8'd4;
    localparam logic [7:0] REG_MIN_DUTY    = 8'd5;
    localparam logic [7:0] REG_MAX_DUTY    = 8'd6;
    localparam logic [7:0] REG_FILTER_GAIN = 8'd7;

    typedef logic [4:0] t_step;

    // Datapath operations selected by a control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_FILT,
        OP_ADD_FILT,
        OP_SET_OFF,
        OP_GO_SPIN,
        OP_SPIN_DUTY,
        OP_GO_ON,
        OP_GO_OFF,
        OP_MAX_DUTY,
        OP_CURVE_PREP,
        OP_CURVE_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_FIN,
        OP_EMIT
    } t_op;

    // Jump conditions; the jump is taken when the condition is true.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_MODE_SPIN,
        C_MODE_ON,
        C_BELOW_ON,
        C_TIME_LEFT,
        C_BELOW_OFF,
        C_EMPTY,
        C_DIV_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // Step addresses of the program.
    localparam t_step S_WAIT       = 5'd0;
    localparam t_step S_MUL_FILT   = 5'd1;
    localparam t_step S_ADD_FILT   = 5'd2;
    localparam t_step S_DISP_SPIN  = 5'd3;
    localparam t_step S_DISP_ON    = 5'd4;
    localparam t_step S_OFF        = 5'd5;
    localparam t_step S_GO_SPIN    = 5'd6;
    localparam t_step S_SPIN       = 5'd7;
    localparam t_step S_GO_ON      = 5'd8;
    localparam t_step S_ON         = 5'd9;
    localparam t_step S_MAX        = 5'd10;
    localparam t_step S_CURVE_PREP = 5'd11;
    localparam t_step S_CURVE_MUL  = 5'd12;
    localparam t_step S_DIV_INIT   = 5'd13;
    localparam t_step S_DIV_STEP   = 5'd14;
    localparam t_step S_DIV_FIN    = 5'd15;
    localparam t_step S_GO_OFF     = 5'd16;
    localparam t_step S_OUT_WAIT   = 5'd17;
    localparam t_step S_EMIT       = 5'd18;

    // Control store: one control word per step.
    function automatic t_uword fsc_rom(input t_step addr);
        t_uword w;
        unique case (addr)
            S_WAIT:       w = '{OP_LOAD,       C_NO_IN,     S_WAIT};
            S_MUL_FILT:   w = '{OP_MUL_FILT,   C_NEVER,     S_WAIT};
            S_ADD_FILT:   w = '{OP_ADD_FILT,   C_NEVER,     S_WAIT};
            S_DISP_SPIN:  w = '{OP_NOP,        C_MODE_SPIN, S_SPIN};
            S_DISP_ON:    w = '{OP_NOP,        C_MODE_ON,   S_ON};
            S_OFF:        w = '{OP_SET_OFF,    C_BELOW_ON,  S_OUT_WAIT};
            S_GO_SPIN:    w = '{OP_GO_SPIN,    C_NEVER,     S_WAIT};
            S_SPIN:       w = '{OP_SPIN_DUTY,  C_TIME_LEFT, S_OUT_WAIT};
            S_GO_ON:      w = '{OP_GO_ON,      C_NEVER,     S_WAIT};
            S_ON:         w = '{OP_NOP,        C_BELOW_OFF, S_GO_OFF};
            S_MAX:        w = '{OP_MAX_DUTY,   C_EMPTY,     S_OUT_WAIT};
            S_CURVE_PREP: w = '{OP_CURVE_PREP, C_NEVER,     S_WAIT};
            S_CURVE_MUL:  w = '{OP_CURVE_MUL,  C_NEVER,     S_WAIT};
            S_DIV_INIT:   w = '{OP_DIV_INIT,   C_NEVER,     S_WAIT};
            S_DIV_STEP:   w = '{OP_DIV_STEP,   C_DIV_MORE,  S_DIV_STEP};
            S_DIV_FIN:    w = '{OP_DIV_FIN,    C_ALWAYS,    S_OUT_WAIT};
            S_GO_OFF:     w = '{OP_GO_OFF,     C_NEVER,     S_WAIT};
            S_OUT_WAIT:   w = '{OP_NOP,        C_OUT_BUSY,  S_OUT_WAIT};
            S_EMIT:       w = '{OP_EMIT,       C_ALWAYS,    S_WAIT};
            default:      w = '{OP_NOP,        C_ALWAYS,    S_WAIT};
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/fan_speed_controller_top.sv */
// Fan speed controller: low-pass filter, spin-up/on/off modes and a duty curve.
//
//   Channel   Direction  Handshake                 Payload
//   s_axis    in         tvalid / tready           temperature sample, timestamp
//   m_axis    out        tvalid / tready           duty, fan mode
//   cfg       in         valid / ready (always 1)  register index, write data
//
// The longest path of a sample from accept to the result beat is the curve, whose
// restoring divider produces a 16-bit quotient.
// Reset is synchronous and active low; it restores the register defaults and clears
// the filter, the mode and the mode change time.
// A result beat held by the sink stalls the sequencer at the wait step before its emit step;
// the next sample is taken only once that result has been handed to the output register.
module fan_speed_controller_top
    import fsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // [15:0] temp_sample, [47:16] time_ms
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // [15:0] duty, [17:16] fan_mode, [23:18] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

`include "fan_speed_controller_top_macros.svh"

    // Configuration registers.
    logic signed [15:0] r_on;
    logic signed [15:0] r_full;
    logic        [14:0] r_hyst;
    logic        [15:0] r_spin_time;
    logic        [15:0] r_spin_duty;
    logic        [15:0] r_min_duty;
    logic        [15:0] r_max_duty;
    logic        [15:0] r_gain;

    // Sequencer and datapath registers.
    t_step              r_pc,       n_pc;
    logic signed [15:0] r_samp,     n_samp;
    logic        [31:0] r_now,      n_now;
    logic signed [23:0] r_filt,     n_filt;
    logic        [1:0]  r_mode,     n_mode;
    logic        [31:0] r_chg,      n_chg;
    logic        [15:0] r_duty,     n_duty;
    logic signed [41:0] r_prod,     n_prod;
    logic        [23:0] r_num,      n_num;
    logic        [23:0] r_span,     n_span;
    logic        [23:0] r_rem,      n_rem;
    logic        [15:0] r_quo,      n_quo;
    logic        [4:0]  r_cnt,      n_cnt;
    logic               r_neg,      n_neg;
    logic               r_out_vld,  n_out_vld;
    logic        [15:0] r_out_duty, n_out_duty;
    logic        [1:0]  r_out_mode, n_out_mode;

    t_uword             uw;
    logic               take_jump;

    logic signed [23:0] lo;
    logic signed [23:0] hi;
    logic signed [16:0] off_lvl;
    logic signed [24:0] off_lvl_q;
    logic               below_on;
    logic               below_off;
    logic               range_empty;
    logic        [31:0] elapsed;
    logic               time_left;
    logic signed [23:0] t_clamp;
    logic signed [24:0] num_full;
    logic signed [24:0] span_full;
    logic signed [24:0] diff;
    logic signed [24:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [41:0] mul_p;
    logic        [41:0] mag;
    logic        [25:0] trial;
    logic               trial_ge;
    logic        [16:0] q_up;
    logic signed [17:0] q_signed;
    logic signed [17:0] y_sum;
    logic        [15:0] y_clamp;

    assign uw              = fsc_rom(r_pc);
    assign o_s_axis_tready = (r_pc == S_WAIT);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'd0, r_out_mode, r_out_duty};

    // Thresholds and comparisons on the filtered temperature (Q8.16).
    always_comb begin
        lo          = {r_on, 8'd0};
        hi          = {r_full, 8'd0};
        off_lvl     = {r_on[15], r_on} - $signed({2'b00, r_hyst});
        off_lvl_q   = {off_lvl, 8'd0};
        below_on    = (r_filt < lo);
        below_off   = ($signed({r_filt[23], r_filt}) < off_lvl_q);
        range_empty = (r_full <= r_on);
        elapsed     = r_now - r_chg;
        time_left   = (elapsed < {16'd0, r_spin_time});
        if (below_on) begin
            t_clamp = lo;
        end else if (r_filt > hi) begin
            t_clamp = hi;
        end else begin
            t_clamp = r_filt;
        end
        num_full  = $signed({t_clamp[23], t_clamp}) - $signed({lo[23], lo});
        span_full = $signed({hi[23], hi}) - $signed({lo[23], lo});
    end

    // Shared multiplier: filter update or curve numerator.
    always_comb begin
        diff = $signed({r_samp[15], r_samp, 8'd0}) - $signed({r_filt[23], r_filt});
        if (uw.op == OP_CURVE_MUL) begin
            mul_a = $signed({1'b0, r_num});
            mul_b = $signed({1'b0, r_max_duty}) - $signed({1'b0, r_min_duty});
        end else begin
            mul_a = diff;
            mul_b = $signed({1'b0, r_gain});
        end
        mul_p = mul_a * mul_b;
    end

    // Restoring divider step, the floor correction of the quotient and the clamped duty sum.
    always_comb begin
        mag      = r_prod[41] ? $unsigned(-r_prod) : $unsigned(r_prod);
        trial    = {1'b0, r_rem, r_quo[15]} - {2'b00, r_span};
        trial_ge = !trial[25];
        q_up     = {1'b0, r_quo} + {16'd0, (r_neg && (r_rem != 24'd0))};
        q_signed = r_neg ? -$signed({1'b0, q_up}) : $signed({1'b0, q_up});
        y_sum    = $signed({2'b00, r_min_duty}) + q_signed;
        if (y_sum < 0) begin
            y_clamp = 16'd0;
        end else if (y_sum > $signed(18'sd65535)) begin
            y_clamp = 16'hFFFF;
        end else begin
            y_clamp = y_sum[15:0];
        end
    end

    // Jump condition select.
    always_comb begin
        case (uw.cond)
            C_NEVER:     take_jump = 1'b0;
            C_ALWAYS:    take_jump = 1'b1;
            C_NO_IN:     take_jump = !i_s_axis_tvalid;
            C_MODE_SPIN: take_jump = (r_mode == MODE_SPINUP);
            C_MODE_ON:   take_jump = (r_mode == MODE_ON);
            C_BELOW_ON:  take_jump = below_on;
            C_TIME_LEFT: take_jump = time_left;
            C_BELOW_OFF: take_jump = below_off;
            C_EMPTY:     take_jump = range_empty;
            C_DIV_MORE:  take_jump = (r_cnt != 5'd1);
            C_OUT_BUSY:  take_jump = r_out_vld && !i_m_axis_tready;
            default:     take_jump = 1'b0;
        endcase
        n_pc = take_jump ? uw.target : r_pc + 5'd1;
    end

    // Datapath operation decode.
    always_comb begin
        n_samp     = r_samp;
        n_now      = r_now;
        n_filt     = r_filt;
        n_mode     = r_mode;
        n_chg      = r_chg;
        n_duty     = r_duty;
        n_prod     = r_prod;
        n_num      = r_num;
        n_span     = r_span;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_cnt      = r_cnt;
        n_neg      = r_neg;
        n_out_duty = r_out_duty;
        n_out_mode = r_out_mode;
        n_out_vld  = r_out_vld && !i_m_axis_tready;
        unique case (uw.op)
            OP_NOP: begin
            end
            OP_LOAD: begin
                n_samp = $signed(i_s_axis_tdata[15:0]);
                n_now  = i_s_axis_tdata[47:16];
            end
            OP_MUL_FILT: begin
                n_prod = mul_p;
            end
            OP_ADD_FILT: begin
                n_filt = r_filt + $signed(r_prod[39:16]);
            end
            OP_SET_OFF: begin
                n_mode = MODE_OFF;
                n_duty = 16'd0;
            end
            OP_GO_SPIN: begin
                n_mode = MODE_SPINUP;
                n_chg  = r_now;
            end
            OP_SPIN_DUTY: begin
                n_duty = r_spin_duty;
            end
            OP_GO_ON: begin
                n_mode = MODE_ON;
                n_chg  = r_now;
            end
            OP_GO_OFF: begin
                n_mode = MODE_OFF;
                n_chg  = r_now;
                n_duty = 16'd0;
            end
            OP_MAX_DUTY: begin
                n_duty = r_max_duty;
            end
            OP_CURVE_PREP: begin
                n_num  = num_full[23:0];
                n_span = span_full[23:0];
            end
            OP_CURVE_MUL: begin
                n_prod = mul_p;
            end
            OP_DIV_INIT: begin
                n_neg = r_prod[41];
                n_rem = mag[39:16];
                n_quo = mag[15:0];
                n_cnt = 5'd16;
            end
            OP_DIV_STEP: begin
                n_rem = trial_ge ? trial[23:0] : {r_rem[22:0], r_quo[15]};
                n_quo = {r_quo[14:0], trial_ge};
                n_cnt = r_cnt - 5'd1;
            end
            OP_DIV_FIN: begin
                n_duty = y_clamp;
            end
            OP_EMIT: begin
                n_out_vld  = 1'b1;
                n_out_duty = r_duty;
                n_out_mode = r_mode;
            end
            default: begin
            end
        endcase
    end

    // Register update: sequencer state, filter, mode and configuration registers are reset, payload registers are not.
    always_ff @(posedge i_clk) begin
        r_samp     <= n_samp;
        r_now      <= n_now;
        r_duty     <= n_duty;
        r_prod     <= n_prod;
        r_num      <= n_num;
        r_span     <= n_span;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_neg      <= n_neg;
        r_out_duty <= n_out_duty;
        r_out_mode <= n_out_mode;
        if (!i_rst_n) begin
            r_pc        <= S_WAIT;
            r_filt      <= '0;
            r_mode      <= MODE_OFF;
            r_chg       <= '0;
            r_out_vld   <= 1'b0;
            r_on        <= 16'sd7680;
            r_full      <= 16'sd12800;
            r_hyst      <= 15'd512;
            r_spin_time <= 16'd2000;
            r_spin_duty <= 16'd65535;
            r_min_duty  <= 16'd19661;
            r_max_duty  <= 16'd65535;
            r_gain      <= 16'd205;
        end else begin
            r_pc      <= n_pc;
            r_filt    <= n_filt;
            r_mode    <= n_mode;
            r_chg     <= n_chg;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_TEMP_ON:     r_on        <= $signed(i_cfg_data);
                    REG_TEMP_FULL:   r_full      <= $signed(i_cfg_data);
                    REG_TEMP_HYST:   r_hyst      <= i_cfg_data[14:0];
                    REG_SPINUP_TIME: r_spin_time <= i_cfg_data;
                    REG_SPINUP_DUTY: r_spin_duty <= i_cfg_data;
                    REG_MIN_DUTY:    r_min_duty  <= i_cfg_data;
                    REG_MAX_DUTY:    r_max_duty  <= i_cfg_data;
                    REG_FILTER_GAIN: r_gain      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // A sample beat always starts the filter multiply in the next cycle.
    `FSC_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_pc == S_MUL_FILT)
    // The divider never iterates with an exhausted count.
    `FSC_ASSERT_IMPL(a_div_count, i_clk, i_rst_n, r_pc == S_DIV_STEP, r_cnt != 5'd0)
    // An off result always carries zero duty.
    `FSC_ASSERT_IMPL(a_off_zero, i_clk, i_rst_n, r_out_vld && (r_out_mode == MODE_OFF), r_out_duty == 16'd0)
    // A spin-up result carries the spin-up duty.
    `FSC_ASSERT_IMPL(a_spin_duty, i_clk, i_rst_n, r_out_vld && (r_out_mode == MODE_SPINUP), r_out_duty == r_spin_duty)

endmodule
